[design/ttps_pkg.sv]
// Shared types, constants and codes for the transposition table probe/store block.
`timescale 1ns / 1ps

package ttps_pkg;

   // Table geometry
   localparam int INDEX_BITS  = 16;
   localparam int TABLE_DEPTH = 1 << INDEX_BITS;

   typedef logic [INDEX_BITS-1:0] index_type;

   // Operation codes carried in req_tuser
   localparam logic OP_PROBE = 1'b0;
   localparam logic OP_STORE = 1'b1;

   // Bound types
   localparam logic [1:0] NODE_EXACT = 2'd0;
   localparam logic [1:0] NODE_LOWER = 2'd1;
   localparam logic [1:0] NODE_UPPER = 2'd2;
   localparam logic [1:0] NODE_NONE  = 2'd3;

   // Values of an empty entry
   localparam logic signed [15:0] EMPTY_SCORE = -16'sd29501;
   localparam logic signed [6:0]  EMPTY_DEPTH = -7'sd1;

   // Request and result word widths, before and after padding to whole bytes
   localparam int REQ_BITS      = 154;
   localparam int REQ_DATA_BITS = 160;
   localparam int RSP_BITS      = 50;
   localparam int RSP_DATA_BITS = 56;

   // One table entry
   typedef struct packed {
      logic [63:0]        hash;
      logic signed [15:0] score;
      logic signed [6:0]  depth;
      logic [1:0]         node_type;
      logic [31:0]        move;
   } entry_type;

   // One request word, unpacked
   typedef struct packed {
      logic               op;
      logic [63:0]        hash;
      logic [5:0]         depth;
      logic signed [15:0] score;
      logic [1:0]         node_type;
      logic [31:0]        move;
      logic signed [15:0] alpha;
      logic signed [15:0] beta;
      logic               not_root;
      logic               single_occurrence;
   } req_type;

   // One result word, unpacked
   typedef struct packed {
      logic               cutoff;
      logic signed [15:0] stored_score;
      logic [31:0]        hint_move;
      logic               written;
   } rsp_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_wr;   // write the empty entry at the sweep address
      logic load_req;   // capture the incoming request word
      logic mem_rd;     // read the indexed entry
      logic commit;     // write back if replaced, load the result register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last; // sweep address is at the last entry
      logic rsp_free;   // result register can take a word this cycle
   } sts_type;

endpackage

[design/transposition_table_probe_store.sv]
// Top level of the depth-preferred transposition table probe/store block.
//
//  channel | ports        | payload
//  --------+--------------+-----------------------------------------------------
//  request | req_t*       | tuser: op; tdata: hash, depth, score, node_type, move,
//          |              |        alpha, beta, not_root, single_occurrence
//  result  | rsp_t*       | tdata: cutoff, stored_score, hint_move, written
//
// An item goes through accept, registered read of the single-port entry memory,
// then compare and write-back into the result register.
// After reset a clearing pass writes the empty entry to all 2^INDEX_BITS entries;
// req_tready stays low until it ends.
// The next word is accepted while a result waits; its update stalls only while the
// result register is still full.
`timescale 1ns / 1ps

module transposition_table_probe_store (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [159:0]  req_tdata,  // hash, depth, score, node_type, move, alpha, beta,
                                     // not_root, single_occurrence, zero pad
   input  logic          req_tuser,  // op
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [55:0]   rsp_tdata   // cutoff, stored_score, hint_move, written, zero pad
);

   ttps_pkg::cmd_type cmd;
   ttps_pkg::sts_type sts;
   ttps_pkg::req_type req_word;
   ttps_pkg::rsp_type rsp_word;

   // Unpack the request word
   always_comb begin
      req_word.op                = req_tuser;
      req_word.hash              = req_tdata[63:0];
      req_word.depth             = req_tdata[69:64];
      req_word.score             = $signed(req_tdata[85:70]);
      req_word.node_type         = req_tdata[87:86];
      req_word.move              = req_tdata[119:88];
      req_word.alpha             = $signed(req_tdata[135:120]);
      req_word.beta              = $signed(req_tdata[151:136]);
      req_word.not_root          = req_tdata[152];
      req_word.single_occurrence = req_tdata[153];
   end

   // Pack the result word
   assign rsp_tdata = {6'd0, rsp_word.written, rsp_word.hint_move,
                       rsp_word.stored_score, rsp_word.cutoff};

   ttps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ttps_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_word   (req_word),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_word   (rsp_word)
   );

   // One item in flight: no word accepted in the cycle after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while previous item still in flight");

   // Result register is never overwritten while it holds an untaken word
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten");

   // Sweep writes never share the memory port with item work
   assert property (@(posedge clock) disable iff (reset)
      cmd.clear_wr |-> (!cmd.mem_rd && !cmd.commit && !req_tready))
      else $error("clearing pass overlaps item work");

   // A result appears only after an update commit
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.commit))
      else $error("result raised without commit");

endmodule

[design/ttps_ctrl.sv]
// Controller state machine: reset sweep, accept, lookup and update sequencing.
`timescale 1ns / 1ps

module ttps_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  ttps_pkg::sts_type  sts,
   output ttps_pkg::cmd_type  cmd
);

   ttps_pkg::state_type state_ff;
   ttps_pkg::state_type state_in;

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ttps_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ttps_pkg::ST_CLEAR: begin
            if (sts.clear_last) begin
               state_in = ttps_pkg::ST_IDLE;
            end
         end
         ttps_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ttps_pkg::ST_LOOKUP;
            end
         end
         ttps_pkg::ST_LOOKUP: begin
            state_in = ttps_pkg::ST_UPDATE;
         end
         ttps_pkg::ST_UPDATE: begin
            if (sts.rsp_free) begin
               state_in = ttps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ttps_pkg::ST_CLEAR;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ttps_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
         end
         ttps_pkg::ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         ttps_pkg::ST_LOOKUP: begin
            cmd.mem_rd = 1'b1;
         end
         ttps_pkg::ST_UPDATE: begin
            cmd.commit = sts.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[design/ttps_datapath.sv]
// Datapath: request register, entry memory, hit and replace logic, result register.
`timescale 1ns / 1ps

module ttps_datapath (
   input  logic               clock,
   input  logic               reset,
   input  ttps_pkg::cmd_type  cmd,
   output ttps_pkg::sts_type  sts,
   input  ttps_pkg::req_type  req_word,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output ttps_pkg::rsp_type  rsp_word
);

   ttps_pkg::entry_type mem [ttps_pkg::TABLE_DEPTH];

   ttps_pkg::req_type   req_ff;
   ttps_pkg::entry_type rd_ff;
   ttps_pkg::rsp_type   rsp_ff;
   ttps_pkg::rsp_type   rsp_in;
   logic                rsp_valid_ff;
   ttps_pkg::index_type clr_addr_ff;

   ttps_pkg::index_type mem_addr;
   ttps_pkg::entry_type mem_wdata;
   logic                mem_we;
   logic                match;
   logic signed [6:0]   req_depth;
   logic                depth_ok;
   logic                bound_ok;
   logic                cutoff;
   logic                replace;

   // Capture the request word
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_word;
      end
   end

   // Advance the reset sweep address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_addr_ff <= ttps_pkg::index_type'(clr_addr_ff + 1'b1);
      end
   end

   // Compare the stored entry against the request
   always_comb begin
      req_depth = $signed({1'b0, req_ff.depth});
      match     = (rd_ff.hash == req_ff.hash);
      depth_ok  = ($signed(rd_ff.depth) >= req_depth);
      case (rd_ff.node_type)
         ttps_pkg::NODE_EXACT: bound_ok = 1'b1;
         ttps_pkg::NODE_LOWER: bound_ok = ($signed(rd_ff.score) >= $signed(req_ff.beta));
         ttps_pkg::NODE_UPPER: bound_ok = ($signed(rd_ff.score) <= $signed(req_ff.alpha));
         default:              bound_ok = 1'b0;
      endcase
      cutoff  = (req_ff.op == ttps_pkg::OP_PROBE) && match && depth_ok
                && req_ff.not_root && req_ff.single_occurrence && bound_ok;
      replace = (req_ff.op == ttps_pkg::OP_STORE)
                && ((req_depth >= $signed(rd_ff.depth)) || !match);
   end

   // Select memory address and write word
   always_comb begin
      if (cmd.clear_wr) begin
         mem_addr            = clr_addr_ff;
         mem_wdata.hash      = '0;
         mem_wdata.score     = ttps_pkg::EMPTY_SCORE;
         mem_wdata.depth     = ttps_pkg::EMPTY_DEPTH;
         mem_wdata.node_type = ttps_pkg::NODE_NONE;
         mem_wdata.move      = '0;
      end else begin
         mem_addr            = req_ff.hash[ttps_pkg::INDEX_BITS-1:0];
         mem_wdata.hash      = req_ff.hash;
         mem_wdata.score     = req_ff.score;
         mem_wdata.depth     = req_depth;
         mem_wdata.node_type = req_ff.node_type;
         mem_wdata.move      = req_ff.move;
      end
      mem_we = cmd.clear_wr || (cmd.commit && replace);
   end

   // Entry memory, single port with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (cmd.mem_rd) begin
         rd_ff <= mem[mem_addr];
      end
   end

   // Build the result word
   always_comb begin
      rsp_in.cutoff       = cutoff;
      rsp_in.stored_score = rd_ff.score;
      rsp_in.hint_move    = rd_ff.move;
      rsp_in.written      = replace;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_word       = rsp_ff;
   assign sts.clear_last = (clr_addr_ff == '1);
   assign sts.rsp_free   = !rsp_valid_ff || rsp_tready;

endmodule

[sim/transposition_table_probe_store_test.sv]
// Self-checking testbench for the transposition table probe/store block.
`timescale 1ns / 1ps

module transposition_table_probe_store_test;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_WORDS = 1030;

   // Receiver stall patterns
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_COIN,
      STALL_EVERY_THIRD,
      STALL_LIGHT
   } stall_mode_type;

   // A request word waiting to be driven, optionally held until the block is empty
   typedef struct {
      ttps_pkg::req_type word;
      bit                drain_first;
   } pending_word_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;  // hash, depth, score, node_type, move, alpha, beta,
                                  // not_root, single_occurrence, zero pad
   logic         req_tuser = ttps_pkg::OP_PROBE;  // op
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [55:0]  rsp_tdata;       // cutoff, stored_score, hint_move, written, zero pad

   // Predicted table contents
   logic [63:0]        tt_hash  [ttps_pkg::TABLE_DEPTH];
   logic signed [15:0] tt_score [ttps_pkg::TABLE_DEPTH];
   logic signed [6:0]  tt_depth [ttps_pkg::TABLE_DEPTH];
   logic [1:0]         tt_type  [ttps_pkg::TABLE_DEPTH];
   logic [31:0]        tt_move  [ttps_pkg::TABLE_DEPTH];

   pending_word_type  pending_words[$];
   ttps_pkg::rsp_type predicted_results[$];
   int                mismatch_count = 0;
   int                cycle_count = 0;

   // Sender burst state
   int burst_left = 0;
   int gap_left = 0;

   // Receiver state
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left = 0;
   int             phase = 0;
   int             valid_seen = 0;
   int             hold_left = 0;
   bit             hold_done = 0;
   bit             ready_next;

   transposition_table_probe_store u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Look up the indexed entry, decide cutoff or replacement, update the table
   function automatic ttps_pkg::rsp_type tt_lookup_update(input ttps_pkg::req_type r);
      ttps_pkg::index_type idx;
      int                  e_score;
      int                  e_depth;
      logic                hit;
      ttps_pkg::rsp_type   res;
      idx = r.hash[ttps_pkg::INDEX_BITS-1:0];
      e_score = int'(tt_score[idx]);
      e_depth = int'(tt_depth[idx]);
      hit = (tt_hash[idx] == r.hash);
      res = '0;
      res.stored_score = tt_score[idx];
      res.hint_move = tt_move[idx];
      if (r.op == ttps_pkg::OP_PROBE) begin
         if (hit && e_depth >= int'(r.depth) && r.not_root && r.single_occurrence) begin
            case (tt_type[idx])
               ttps_pkg::NODE_EXACT: res.cutoff = 1'b1;
               ttps_pkg::NODE_LOWER: res.cutoff = (e_score >= int'($signed(r.beta)));
               ttps_pkg::NODE_UPPER: res.cutoff = (e_score <= int'($signed(r.alpha)));
               default:              res.cutoff = 1'b0;
            endcase
         end
      end else if (int'(r.depth) >= e_depth || !hit) begin
         tt_hash[idx]  = r.hash;
         tt_score[idx] = r.score;
         tt_depth[idx] = {1'b0, r.depth};
         tt_type[idx]  = r.node_type;
         tt_move[idx]  = r.move;
         res.written = 1'b1;
      end
      return res;
   endfunction

   task automatic queue_word(input logic op, input logic [63:0] hash, input logic [5:0] depth,
                             input logic signed [15:0] score, input logic [1:0] node_type,
                             input logic [31:0] move, input logic signed [15:0] alpha,
                             input logic signed [15:0] beta, input logic not_root,
                             input logic single_occurrence, input bit drain_first);
      pending_word_type p;
      p.word.op = op;
      p.word.hash = hash;
      p.word.depth = depth;
      p.word.score = score;
      p.word.node_type = node_type;
      p.word.move = move;
      p.word.alpha = alpha;
      p.word.beta = beta;
      p.word.not_root = not_root;
      p.word.single_occurrence = single_occurrence;
      p.drain_first = drain_first;
      pending_words.push_back(p);
   endtask

   // Drive request words in bursts; hold off before a word marked to wait for an empty block
   always @(posedge clock) begin
      pending_word_type p;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_words.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (pending_words[0].drain_first &&
                      (req_tvalid || predicted_results.size() != 0)) begin
            req_tvalid <= 1'b0;
         end else begin
            p = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= p.word.op;
            req_tdata  <= {6'b0, p.word.single_occurrence, p.word.not_root, p.word.beta,
                           p.word.alpha, p.word.move, p.word.node_type, p.word.score,
                           p.word.depth, p.word.hash};
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               case ($urandom_range(0, 7))
                  0, 1:    gap_left = 0;
                  7:       gap_left = $urandom_range(13, 30);
                  default: gap_left = $urandom_range(1, 12);
               endcase
            end
         end
      end
   end

   // Stall the result channel on shifting patterns, and once for a long stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         phase++;
         if (rsp_tvalid) valid_seen++;
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (valid_seen >= 300 && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 400;
            ready_next = 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 96);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               STALL_NONE:        ready_next = 1'b1;
               STALL_COIN:        ready_next = ($urandom_range(0, 1) != 0);
               STALL_EVERY_THIRD: ready_next = (phase % 3 == 0);
               default:           ready_next = ($urandom_range(0, 3) != 0);
            endcase
         end
         rsp_tready <= ready_next;
      end
   end

   // Predict on each accepted request word, check each accepted result word
   always @(posedge clock) begin
      ttps_pkg::req_type accepted;
      ttps_pkg::rsp_type predicted;
      ttps_pkg::rsp_type observed;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            accepted.op                = req_tuser;
            accepted.hash              = req_tdata[63:0];
            accepted.depth             = req_tdata[69:64];
            accepted.score             = req_tdata[85:70];
            accepted.node_type         = req_tdata[87:86];
            accepted.move              = req_tdata[119:88];
            accepted.alpha             = req_tdata[135:120];
            accepted.beta              = req_tdata[151:136];
            accepted.not_root          = req_tdata[152];
            accepted.single_occurrence = req_tdata[153];
            predicted_results.push_back(tt_lookup_update(accepted));
         end
         if (rsp_tvalid && rsp_tready) begin
            observed.cutoff       = rsp_tdata[0];
            observed.stored_score = rsp_tdata[16:1];
            observed.hint_move    = rsp_tdata[48:17];
            observed.written      = rsp_tdata[49];
            if (predicted_results.size() == 0) begin
               $error("result word with no request outstanding: %h", rsp_tdata);
               mismatch_count++;
            end else begin
               predicted = predicted_results.pop_front();
               if (observed.cutoff !== predicted.cutoff) begin
                  $error("cutoff: expected %0d, got %0d", predicted.cutoff, observed.cutoff);
                  mismatch_count++;
               end
               if (observed.stored_score !== predicted.stored_score) begin
                  $error("stored_score: expected %0d, got %0d",
                         predicted.stored_score, observed.stored_score);
                  mismatch_count++;
               end
               if (observed.hint_move !== predicted.hint_move) begin
                  $error("hint_move: expected %h, got %h",
                         predicted.hint_move, observed.hint_move);
                  mismatch_count++;
               end
               if (observed.written !== predicted.written) begin
                  $error("written: expected %0d, got %0d", predicted.written, observed.written);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Give up on a hung block
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      ttps_pkg::index_type hot_index [6];
      logic [63:0]         hot_hash  [24];
      logic [63:0]         hash;
      logic                op;
      logic [5:0]          depth;
      logic signed [15:0]  score;
      logic signed [15:0]  alpha;
      logic signed [15:0]  beta;
      logic [1:0]          node_type;

      // Start from the empty table
      for (int i = 0; i < ttps_pkg::TABLE_DEPTH; i++) begin
         tt_hash[i]  = '0;
         tt_score[i] = ttps_pkg::EMPTY_SCORE;
         tt_depth[i] = ttps_pkg::EMPTY_DEPTH;
         tt_type[i]  = ttps_pkg::NODE_NONE;
         tt_move[i]  = '0;
      end

      // Directed: empty entry, each bound type, root and repetition gating, replacement rules
      queue_word(ttps_pkg::OP_PROBE, 64'h0, 6'd0, 16'sd0, ttps_pkg::NODE_EXACT, 32'h0,
                 16'sd0, 16'sd0, 1, 1, 0);
      queue_word(ttps_pkg::OP_STORE, 64'h0, 6'd0, 16'sd30000, ttps_pkg::NODE_EXACT,
                 32'hFFFF_FFFF, 16'sd0, 16'sd0, 1, 1, 0);
      queue_word(ttps_pkg::OP_PROBE, 64'h0, 6'd0, 16'sd0, ttps_pkg::NODE_EXACT, 32'h0,
                 16'sd0, 16'sd0, 1, 1, 0);
      queue_word(ttps_pkg::OP_PROBE, 64'h0, 6'd0, 16'sd0, ttps_pkg::NODE_EXACT, 32'h0,
                 16'sd0, 16'sd0, 0, 1, 0);
      queue_word(ttps_pkg::OP_PROBE, 64'h0, 6'd0, 16'sd0, ttps_pkg::NODE_EXACT, 32'h0,
                 16'sd0, 16'sd0, 1, 0, 0);
      queue_word(ttps_pkg::OP_PROBE, 64'h0, 6'd1, 16'sd0, ttps_pkg::NODE_EXACT, 32'h0,
                 16'sd0, 16'sd0, 1, 1, 0);
      queue_word(ttps_pkg::OP_STORE, 64'h0, 6'd63, -16'sd30000, ttps_pkg::NODE_LOWER,
                 32'h0000_1234, 16'sd0, 16'sd0, 1, 1, 0);
      queue_word(ttps_pkg::OP_PROBE, 64'h0, 6'd63, 16'sd0, ttps_pkg::NODE_EXACT, 32'h0,
                 16'sd0, -16'sd30000, 1, 1, 0);
      queue_word(ttps_pkg::OP_PROBE, 64'h0, 6'd10, 16'sd0, ttps_pkg::NODE_EXACT, 32'h0,
                 16'sd0, -16'sd29999, 1, 1, 0);
      queue_word(ttps_pkg::OP_STORE, 64'h0, 6'd62, 16'sd7, ttps_pkg::NODE_EXACT, 32'h5,
                 16'sd0, 16'sd0, 1, 1, 0);
      // Same index, different hash: always replaced
      queue_word(ttps_pkg::OP_STORE, 64'hFFFF_FFFF_FFFF_0000, 6'd0, 16'sd100,
                 ttps_pkg::NODE_UPPER, 32'hA5A5_5A5A, 16'sd0, 16'sd0, 1, 1, 0);
      queue_word(ttps_pkg::OP_PROBE, 64'hFFFF_FFFF_FFFF_0000, 6'd0, 16'sd0,
                 ttps_pkg::NODE_EXACT, 32'h0, 16'sd100, 16'sd0, 1, 1, 0);
      queue_word(ttps_pkg::OP_PROBE, 64'hFFFF_FFFF_FFFF_0000, 6'd0, 16'sd0,
                 ttps_pkg::NODE_EXACT, 32'h0, 16'sd99, 16'sd0, 1, 1, 0);
      // Bound type none never cuts off
      queue_word(ttps_pkg::OP_STORE, 64'hFFFF_FFFF_FFFF_0000, 6'd0, 16'sd5,
                 ttps_pkg::NODE_NONE, 32'h1, 16'sd0, 16'sd0, 1, 1, 0);
      queue_word(ttps_pkg::OP_PROBE, 64'hFFFF_FFFF_FFFF_0000, 6'd0, 16'sd0,
                 ttps_pkg::NODE_EXACT, 32'h0, 16'sd30000, -16'sd30000, 1, 1, 0);
      // Scores beyond the nominal range
      queue_word(ttps_pkg::OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 16'sh7FFF,
                 ttps_pkg::NODE_EXACT, 32'h8000_0001, 16'sd0, 16'sd0, 1, 1, 0);
      queue_word(ttps_pkg::OP_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 16'sd0,
                 ttps_pkg::NODE_EXACT, 32'h0, 16'sd0, 16'sd0, 1, 1, 0);
      queue_word(ttps_pkg::OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 16'sh8000,
                 ttps_pkg::NODE_LOWER, 32'h7FFF_FFFE, 16'sd0, 16'sd0, 1, 1, 0);
      queue_word(ttps_pkg::OP_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 16'sd0,
                 ttps_pkg::NODE_EXACT, 32'h0, 16'sd0, 16'sh8000, 1, 1, 0);
      queue_word(ttps_pkg::OP_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 16'sd0,
                 ttps_pkg::NODE_EXACT, 32'h0, 16'sd0, 16'sh8001, 1, 1, 0);
      queue_word(ttps_pkg::OP_STORE, 64'h5555_AAAA_5555_AAAA, 6'd31, 16'sd0,
                 ttps_pkg::NODE_UPPER, 32'h0, 16'sd0, 16'sd0, 1, 1, 0);
      queue_word(ttps_pkg::OP_PROBE, 64'h5555_AAAA_5555_AAAA, 6'd31, 16'sd0,
                 ttps_pkg::NODE_EXACT, 32'h0, 16'sd0, 16'sh7FFF, 1, 1, 0);
      queue_word(ttps_pkg::OP_PROBE, 64'h5555_AAAA_5555_AAAA, 6'd31, 16'sd0,
                 ttps_pkg::NODE_EXACT, 32'h0, 16'sh8000, 16'sh7FFF, 1, 1, 0);

      // A few hot indexes, each shared by several hashes, so stores and probes collide
      for (int i = 0; i < 6; i++) hot_index[i] = ttps_pkg::index_type'($urandom);
      for (int i = 0; i < 24; i++) begin
         hot_hash[i] = {$urandom, $urandom};
         hot_hash[i][ttps_pkg::INDEX_BITS-1:0] = hot_index[i % 6];
      end

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if ($urandom_range(0, 9) < 8) hash = hot_hash[$urandom_range(0, 23)];
         else hash = {$urandom, $urandom};
         op = ($urandom_range(0, 99) < 45) ? ttps_pkg::OP_STORE : ttps_pkg::OP_PROBE;
         if (op == ttps_pkg::OP_PROBE && $urandom_range(0, 1) != 0) begin
            depth = 6'($urandom_range(0, 16));
         end else begin
            depth = 6'($urandom_range(0, 63));
         end
         if ($urandom_range(0, 15) == 0) score = 16'($urandom);
         else score = 16'($urandom_range(0, 60000) - 30000);
         if ($urandom_range(0, 15) == 0) node_type = ttps_pkg::NODE_NONE;
         else node_type = 2'($urandom_range(0, 2));
         if ($urandom_range(0, 15) == 0) begin
            alpha = 16'($urandom);
            beta  = 16'($urandom);
         end else begin
            alpha = 16'($urandom_range(0, 60000) - 30000);
            beta  = 16'($urandom_range(0, 60000) - 30000);
         end
         queue_word(op, hash, depth, score, node_type, $urandom, alpha, beta,
                    $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0,
                    n == 0 || n == 400 || n == 800);
      end

      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Wait for every word to go in, every result to come out, then a short quiet spell
      while (pending_words.size() != 0 || req_tvalid) @(posedge clock);
      while (predicted_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
